// File: rtl/multi_oscillator_mixer_assert.svh
// assertion macros shared by the mixer rtl
// expects clk and rst (synchronous, active high) in the including module
`ifndef MULTI_OSCILLATOR_MIXER_ASSERT_SVH
`define MULTI_OSCILLATOR_MIXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MOM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MOM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mom_pkg.sv
// shared types, constants and the quarter-wave sine table of the mixer
// no dependencies
package mom_pkg;

  localparam int NUM_OSC         = 16;
  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;

  localparam int IDX_W      = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int STEP_BITS  = 24;
  localparam int GAIN_BITS  = 25;
  localparam int SLOPE_BITS = 24;
  localparam int MAG_BITS   = 15;
  localparam int SUM_W      = 16 + IDX_W + 1;

  localparam int FULL_GAIN  = 1 << 24;
  localparam int AMPLITUDE  = 32767;
  localparam int TRI_SCALE  = 131068;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QSIZE = 1 << QBITS;

  // odd taylor coefficients of sin(pi/2*x) in q30
  localparam logic [63:0] SC1 = 64'd1686629713;
  localparam logic [63:0] SC3 = 64'd693598668;
  localparam logic [63:0] SC5 = 64'd85569306;
  localparam logic [63:0] SC7 = 64'd5026995;
  localparam logic [63:0] SC9 = 64'd172272;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef enum logic [1:0] {
    WAVE_OFF   = 2'd0,
    WAVE_SINE  = 2'd1,
    WAVE_NOISE = 2'd2,
    WAVE_TRI   = 2'd3
  } wave_t;

  typedef struct packed {
    wave_t                  kind;
    logic [PHASE_BITS-1:0]  phase;
    logic [PHASE_BITS-1:0]  inc;
    logic [GAIN_BITS-1:0]   level;
    logic [SLOPE_BITS-1:0]  slope;
  } osc_rec_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    osc_rec_t          rec;
  } wb_t;

  typedef struct packed {
    logic                  valid;
    logic                  neg;
    logic [MAG_BITS-1:0]   mag;
    logic [GAIN_BITS-1:0]  level;
  } mix_t;

  typedef logic [MAG_BITS-1:0] sine_quarter_t [QSIZE+1];

  // quarter-wave amplitudes, evaluated at elaboration
  function automatic sine_quarter_t build_sine_quarter();
    sine_quarter_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] amp;
    for (int r = 0; r <= QSIZE; r++) begin
      x   = 64'(r) << (30 - QBITS);
      x2  = (x * x) >> 30;
      t   = SC7 - ((x2 * SC9) >> 30);
      t   = SC5 - ((x2 * t) >> 30);
      t   = SC3 - ((x2 * t) >> 30);
      t   = SC1 - ((x2 * t) >> 30);
      y   = (x * t) >> 30;
      amp = (y * 64'(AMPLITUDE) + (64'd1 << 29)) >> 30;
      if (amp > 64'(AMPLITUDE)) begin
        amp = 64'(AMPLITUDE);
      end
      tab[r] = amp[MAG_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_quarter_t SINE_Q = build_sine_quarter();

endpackage

// File: rtl/mom_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/mom_voice.sv
// per-oscillator update stage: waveform value, phase and gain ramp, write-back
// depends on mom_pkg and multi_oscillator_mixer_assert.svh
`include "multi_oscillator_mixer_assert.svh"

module mom_voice (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       active,
  input  logic [mom_pkg::IDX_W-1:0]  idx,
  input  mom_pkg::osc_rec_t          rec,
  output mom_pkg::wb_t               wb,
  output mom_pkg::mix_t              mix
);

  localparam int PB  = mom_pkg::PHASE_BITS;
  localparam int STB = mom_pkg::SINE_TABLE_BITS;
  localparam int QB  = mom_pkg::QBITS;
  localparam int MB  = mom_pkg::MAG_BITS;

  localparam logic [PB-1:0] HALF    = PB'(1) << (PB - 1);
  localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);
  localparam logic [QB:0]   QSIZE_V = (QB + 1)'(mom_pkg::QSIZE);
  localparam logic signed [26:0] FULL_S = 27'(mom_pkg::FULL_GAIN);

  logic [15:0] noise;

  // sine
  logic [PB+STB-1:0] idx_ext;
  logic [STB-1:0]    sidx;
  logic [1:0]        quad;
  logic [QB:0]       qr;
  logic [MB-1:0]     sine_mag;

  // triangle
  logic [PB-1:0]   diff;
  logic [PB-1:0]   tri_full;
  logic            tri_neg;
  logic [PB+15:0]  tri_prod;
  logic [MB-1:0]   tri_mag;

  // noise
  logic          nbit;
  logic [15:0]   noise_next;
  logic [14:0]   noise_low;
  logic          noise_neg;
  logic [MB-1:0] noise_mag;

  logic          val_neg;
  logic [MB-1:0] val_mag;
  logic          is_on;

  logic signed [26:0]              nl;
  logic [mom_pkg::GAIN_BITS-1:0]   new_level;

  assign idx_ext  = {rec.phase, STB'(0)};
  assign sidx     = idx_ext[PB+STB-1:PB];
  assign quad     = sidx[STB-1:STB-2];
  // second and fourth quarters run the table backwards
  assign qr       = quad[0] ? (QSIZE_V - {1'b0, sidx[QB-1:0]}) : {1'b0, sidx[QB-1:0]};
  assign sine_mag = mom_pkg::SINE_Q[qr];

  assign diff     = (rec.phase >= HALF) ? (rec.phase - HALF) : (HALF - rec.phase);
  assign tri_neg  = diff < QUARTER;
  assign tri_full = tri_neg ? (QUARTER - diff) : (diff - QUARTER);
  assign tri_prod = (PB + 16)'(tri_full[PB-2:0]) * (PB + 16)'(mom_pkg::TRI_SCALE);
  assign tri_mag  = tri_prod[PB+14:PB];

  assign nbit       = noise[0] ^ noise[2] ^ noise[3] ^ noise[5];
  assign noise_next = {nbit, noise[15:1]};
  assign noise_low  = noise_next[14:0];
  assign noise_neg  = !noise_low[14];
  assign noise_mag  = noise_neg ? (MB'(16384) - MB'(noise_low)) : MB'(noise_low[13:0]);

  always_comb begin
    val_neg = 1'b0;
    val_mag = '0;
    unique case (rec.kind)
      mom_pkg::WAVE_SINE: begin
        val_neg = quad[1];
        val_mag = sine_mag;
      end
      mom_pkg::WAVE_TRI: begin
        val_neg = tri_neg;
        val_mag = tri_mag;
      end
      mom_pkg::WAVE_NOISE: begin
        val_neg = noise_neg;
        val_mag = noise_mag;
      end
      mom_pkg::WAVE_OFF: begin
      end
    endcase
  end

  assign is_on = active && (rec.kind != mom_pkg::WAVE_OFF);

  // gain ramp with clamp to 0..full scale
  assign nl = $signed({2'b00, rec.level}) + $signed({{3{rec.slope[23]}}, rec.slope});
  assign new_level = nl[26] ? '0 :
                     (nl > FULL_S) ? mom_pkg::GAIN_BITS'(mom_pkg::FULL_GAIN) :
                     nl[mom_pkg::GAIN_BITS-1:0];

  always_comb begin
    wb.en        = is_on;
    wb.addr      = idx;
    wb.rec       = rec;
    wb.rec.level = new_level;
    if (rec.kind != mom_pkg::WAVE_NOISE) begin
      wb.rec.phase = rec.phase + rec.inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise     <= mom_pkg::LFSR_SEED;
      mix.valid <= 1'b0;
    end else begin
      mix.valid <= is_on;
      if (is_on && rec.kind == mom_pkg::WAVE_NOISE) begin
        noise <= noise_next;
      end
    end
    mix.neg   <= val_neg;
    mix.mag   <= val_mag;
    mix.level <= rec.level;
  end

  `MOM_ASSERT_IMP(a_level_clamped, wb.en, wb.rec.level <= 25'(mom_pkg::FULL_GAIN), "gain above full scale")
  `MOM_ASSERT_IMP(a_noise_live, 1'b1, noise != 16'd0, "noise register stuck at zero")

endmodule

// File: rtl/mom_mixer.sv
// gain multiply, accumulation over a tick, and 16-bit saturation
// depends on mom_pkg
module mom_mixer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  mom_pkg::mix_t        mix,
  output logic                 busy,
  output logic signed [15:0]   sat_sample,
  output logic                 sat_clip
);

  localparam int SW = mom_pkg::SUM_W;
  localparam int MB = mom_pkg::MAG_BITS;
  localparam int PW = MB + mom_pkg::GAIN_BITS;
  localparam logic signed [SW-1:0] HI = SW'(mom_pkg::SAMPLE_MAX);
  localparam logic signed [SW-1:0] LO = SW'(mom_pkg::SAMPLE_MIN);

  logic [PW-1:0]        prod;
  logic [MB-1:0]        scaled;
  logic                 s3_valid;
  logic signed [15:0]   s3_contrib;
  logic signed [SW-1:0] acc;

  assign prod   = PW'(mix.mag) * PW'(mix.level);
  assign scaled = prod[MB+23:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= mix.valid;
    end
    s3_contrib <= mix.neg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
    if (clear) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= acc + SW'(s3_contrib);
    end
  end

  assign busy = s3_valid;

  always_comb begin
    sat_clip = 1'b1;
    priority if (acc > HI) begin
      sat_sample = 16'(mom_pkg::SAMPLE_MAX);
    end else if (acc < LO) begin
      sat_sample = 16'(mom_pkg::SAMPLE_MIN);
    end else begin
      sat_sample = acc[15:0];
      sat_clip   = 1'b0;
    end
  end

endmodule

// File: rtl/multi_oscillator_mixer.sv
// Bank of phase-accumulator oscillators (sine, triangle, noise) mixed into
// one saturated 16-bit sample per tick.
//
// Input channel (item_valid / item_stall): action selects load or tick.
// A load writes one oscillator slot (kind, phase step, start gain, gain ramp)
// and clears its phase; it returns nothing. Loads naming a slot beyond the
// bank are dropped.
// A tick walks every slot through the state ram, one slot per cycle, and
// returns one result (sample, clipped) on the result channel.
// The walk is paced by the single read port of the oscillator ram; no new
// item is taken until a tick has issued its result, so ticks never overlap.
// Loads run at one per cycle while no tick is in progress.
// Results sit in an output register: items are still taken while a result
// waits, but a tick finishing while the receiver stalls holds in its last
// step until the output register frees.
// Reset: synchronous; every slot reads as off with zero state through per-slot
// valid bits (no clearing pass), the noise generator restarts from its seed.
// depends on mom_pkg, mom_ram, mom_voice, mom_mixer, multi_oscillator_mixer_assert.svh
`include "multi_oscillator_mixer_assert.svh"

module multi_oscillator_mixer (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                action,
  input  logic [3:0]          osc_index,
  input  logic [1:0]          wave_type,
  input  logic [23:0]         phase_step,
  input  logic [24:0]         start_gain,
  input  logic signed [23:0]  gain_step,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [15:0]  sample,
  output logic                clipped
);

  localparam int IW = mom_pkg::IDX_W;
  localparam int PB = mom_pkg::PHASE_BITS;
  localparam int RW = $bits(mom_pkg::osc_rec_t);
  localparam logic [IW-1:0] LAST = IW'(mom_pkg::NUM_OSC - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t state;
  logic [IW-1:0] cnt;
  logic          rd_q;
  logic [IW-1:0] a_idx;
  logic          a_entry_valid;
  logic [mom_pkg::NUM_OSC-1:0] slot_valid;

  logic item_xfer;
  logic tick_xfer;
  logic load_ok;
  logic rd_en;
  logic pipe_empty;
  logic finish;

  logic [PB+23:0]     step_ext;
  mom_pkg::osc_rec_t  load_rec;
  mom_pkg::osc_rec_t  rd_rec;
  logic [RW-1:0]      ram_q;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [RW-1:0]      ram_wdata;

  mom_pkg::wb_t       wb;
  mom_pkg::mix_t      mix;
  logic               mix_busy;
  logic signed [15:0] sat_sample;
  logic               sat_clip;

  assign item_stall = (state != ST_IDLE);
  assign item_xfer  = item_valid && !item_stall;
  assign tick_xfer  = item_xfer && (action == mom_pkg::ACT_TICK);
  assign load_ok    = item_xfer && (action == mom_pkg::ACT_LOAD) &&
                      (32'(osc_index) < 32'(mom_pkg::NUM_OSC));

  // phase step rescaled from 24 fraction bits to the phase width
  assign step_ext = {phase_step, PB'(0)};

  always_comb begin
    load_rec.kind  = mom_pkg::wave_t'(wave_type);
    load_rec.phase = '0;
    load_rec.inc   = step_ext[PB+23:24];
    load_rec.level = (start_gain > 25'(mom_pkg::FULL_GAIN)) ?
                     25'(mom_pkg::FULL_GAIN) : start_gain;
    load_rec.slope = gain_step;
  end

  // loads only happen while idle, write-back only during a tick
  assign ram_we    = load_ok || wb.en;
  assign ram_waddr = load_ok ? IW'(osc_index) : wb.addr;
  assign ram_wdata = load_ok ? RW'(load_rec) : RW'(wb.rec);
  assign rd_en     = (state == ST_RUN);

  mom_ram #(
    .WIDTH(RW),
    .DEPTH(mom_pkg::NUM_OSC)
  ) u_osc_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(cnt),
    .rdata(ram_q)
  );

  // never-loaded slots read as off
  assign rd_rec = a_entry_valid ? mom_pkg::osc_rec_t'(ram_q) : '0;

  mom_voice u_voice (
    .clk   (clk),
    .rst   (rst),
    .active(rd_q),
    .idx   (a_idx),
    .rec   (rd_rec),
    .wb    (wb),
    .mix   (mix)
  );

  mom_mixer u_mixer (
    .clk       (clk),
    .rst       (rst),
    .clear     (tick_xfer),
    .mix       (mix),
    .busy      (mix_busy),
    .sat_sample(sat_sample),
    .sat_clip  (sat_clip)
  );

  assign pipe_empty = !rd_q && !mix.valid && !mix_busy;
  assign finish     = (state == ST_DRAIN) && pipe_empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      rd_q         <= 1'b0;
      result_valid <= 1'b0;
      slot_valid   <= '0;
    end else begin
      rd_q <= rd_en;
      if (load_ok) begin
        slot_valid[IW'(osc_index)] <= 1'b1;
      end
      // a finishing tick refills the output register in the same cycle
      if (result_valid && !result_stall && !finish) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (tick_xfer) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (cnt == LAST) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            state        <= ST_IDLE;
            result_valid <= 1'b1;
            sample       <= sat_sample;
            clipped      <= sat_clip;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    a_idx         <= cnt;
    a_entry_valid <= slot_valid[cnt];
  end

  `MOM_ASSERT_IMP(a_wb_in_tick, wb.en, state != ST_IDLE, "write-back outside a tick")
  `MOM_ASSERT_NXT(a_load_single, item_xfer && action == mom_pkg::ACT_LOAD, state == ST_IDLE, "load did not finish in one cycle")
  `MOM_ASSERT_NXT(a_tick_start, tick_xfer, state == ST_RUN && cnt == '0, "tick did not start at slot zero")
  `MOM_ASSERT_IMP(a_finish_empty, $rose(result_valid), $past(state) == ST_DRAIN, "result issued before the walk drained")

endmodule

// File: sim/mix_checker.sv
// checker for the oscillator mixer: watches both channels, predicts each tick's sample
// from its own copy of the oscillator bank and compares in order
// depends on mom_pkg
module mix_checker
  import mom_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic               action,
  input  logic [3:0]         osc_index,
  input  logic [1:0]         wave_type,
  input  logic [23:0]        phase_step,
  input  logic [24:0]        start_gain,
  input  logic signed [23:0] gain_step,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [15:0] sample,
  input  logic               clipped,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] sample;
    logic               clipped;
  } mix_result_t;

  wave_t                   kind  [NUM_OSC];
  logic [PHASE_BITS-1:0]   phase [NUM_OSC];
  logic [PHASE_BITS-1:0]   incr  [NUM_OSC];
  logic [GAIN_BITS-1:0]    level [NUM_OSC];
  logic signed [SLOPE_BITS-1:0] slope [NUM_OSC];
  logic [15:0]             lfsr;
  mix_result_t             expected_mix [$];
  int                      errors = 0;

  function automatic int sine_level(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]  quad;
    logic [QBITS:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] amp;
    idx  = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r    = {1'b0, idx[QBITS-1:0]};
    // second and fourth quarters run the quarter wave backwards
    if (quad[0]) begin
      r = (QBITS+1)'(QSIZE) - r;
    end
    x   = 64'(r) << (30 - QBITS);
    x2  = (x * x) >> 30;
    t   = SC7 - ((x2 * SC9) >> 30);
    t   = SC5 - ((x2 * t) >> 30);
    t   = SC3 - ((x2 * t) >> 30);
    t   = SC1 - ((x2 * t) >> 30);
    y   = (x * t) >> 30;
    amp = (y * 64'(AMPLITUDE) + (64'd1 << 29)) >> 30;
    if (amp > 64'(AMPLITUDE)) begin
      amp = 64'(AMPLITUDE);
    end
    return quad[1] ? -int'(amp) : int'(amp);
  endfunction

  function automatic int triangle_level(input logic [PHASE_BITS-1:0] ph);
    logic [63:0] half;
    logic [63:0] quarter;
    logic [63:0] d;
    half    = 64'd1 << (PHASE_BITS - 1);
    quarter = 64'd1 << (PHASE_BITS - 2);
    d = (64'(ph) >= half) ? 64'(ph) - half : half - 64'(ph);
    if (d >= quarter) begin
      return int'(((d - quarter) * 64'(TRI_SCALE)) >> PHASE_BITS);
    end
    return -int'(((quarter - d) * 64'(TRI_SCALE)) >> PHASE_BITS);
  endfunction

  // magnitude times gain, truncated toward zero
  function automatic int scale_gain(input int v, input logic [GAIN_BITS-1:0] g);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (v < 0) ? 64'(-v) : 64'(v);
    prod = (mag * 64'(g)) >> 24;
    return (v < 0) ? -int'(prod) : int'(prod);
  endfunction

  task automatic next_sample(output mix_result_t res);
    int     sum;
    int     v;
    longint nl;
    logic   fb;
    sum = 0;
    for (int i = 0; i < NUM_OSC; i++) begin
      if (kind[i] == WAVE_OFF) begin
        continue;
      end
      case (kind[i])
        WAVE_SINE: begin
          v = sine_level(phase[i]);
          phase[i] += incr[i];
        end
        WAVE_TRI: begin
          v = triangle_level(phase[i]);
          phase[i] += incr[i];
        end
        default: begin
          // noise keeps its phase, the shared lfsr steps once per noise slot
          fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
          lfsr = {fb, lfsr[15:1]};
          v    = int'({1'b0, lfsr[14:0]}) - 16384;
        end
      endcase
      sum += scale_gain(v, level[i]);
      nl = longint'(level[i]) + longint'(slope[i]);
      if (nl < 0) begin
        nl = 0;
      end else if (nl > FULL_GAIN) begin
        nl = FULL_GAIN;
      end
      level[i] = GAIN_BITS'(nl);
    end
    res.clipped = 1'b0;
    if (sum > SAMPLE_MAX) begin
      sum = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (sum < SAMPLE_MIN) begin
      sum = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample = 16'(sum);
  endtask

  always @(posedge clk) begin : watch
    mix_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_OSC; i++) begin
        kind[i]  = WAVE_OFF;
        phase[i] = '0;
        incr[i]  = '0;
        level[i] = '0;
        slope[i] = '0;
      end
      lfsr = LFSR_SEED;
      expected_mix.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_mix.size() == 0) begin
          $error("sample: expected none, actual %0d", sample);
          errors++;
        end else begin
          want = expected_mix.pop_front();
          if (sample !== want.sample) begin
            $error("sample: expected %0d, actual %0d", want.sample, sample);
            errors++;
          end
          if (clipped !== want.clipped) begin
            $error("clipped: expected %0d, actual %0d", want.clipped, clipped);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (action == ACT_LOAD) begin
          if (int'(osc_index) < NUM_OSC) begin
            kind[osc_index]  = wave_t'(wave_type);
            phase[osc_index] = '0;
            incr[osc_index]  = phase_step;
            level[osc_index] = (start_gain > FULL_GAIN) ? GAIN_BITS'(FULL_GAIN) : start_gain;
            slope[osc_index] = gain_step;
          end
        end else begin
          next_sample(want);
          expected_mix.push_back(want);
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_mix.size();
  end

endmodule

// File: sim/tb.sv
// testbench top for the oscillator mixer: clock, reset, stimulus and receiver stalls
// depends on mom_pkg, multi_oscillator_mixer and mix_checker
module tb;
  import mom_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int END_CYCLES  = 60;
  localparam int LIMIT       = 400000;

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  logic               action       = ACT_TICK;
  logic [3:0]         osc_index    = '0;
  logic [1:0]         wave_type    = WAVE_OFF;
  logic [23:0]        phase_step   = '0;
  logic [24:0]        start_gain   = '0;
  logic signed [23:0] gain_step    = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [15:0] sample;
  logic               clipped;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  bit no_idle       = 1'b0;

  multi_oscillator_mixer u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .action      (action),
    .osc_index   (osc_index),
    .wave_type   (wave_type),
    .phase_step  (phase_step),
    .start_gain  (start_gain),
    .gain_step   (gain_step),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sample      (sample),
    .clipped     (clipped)
  );

  mix_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .action      (action),
    .osc_index   (osc_index),
    .wave_type   (wave_type),
    .phase_step  (phase_step),
    .start_gain  (start_gain),
    .gain_step   (gain_step),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sample      (sample),
    .clipped     (clipped),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (no_idle) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic act, input logic [3:0] idx, input wave_t wv,
                           input logic [23:0] stp, input logic [24:0] g0,
                           input logic [23:0] gs);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    osc_index  <= idx;
    wave_type  <= wv;
    phase_step <= stp;
    start_gain <= g0;
    gain_step  <= gs;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
  endtask

  // tick with junk in the load-only fields
  task automatic tick();
    send_item(ACT_TICK, 4'($urandom), wave_t'($urandom_range(3)), 24'($urandom),
              25'($urandom), 24'($urandom));
  endtask

  task automatic load(input logic [3:0] idx, input wave_t wv, input logic [23:0] stp,
                      input logic [24:0] g0, input logic [23:0] gs);
    send_item(ACT_LOAD, idx, wv, stp, g0, gs);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic random_item(input bit loud);
    logic [24:0] g0;
    logic [23:0] gs;
    logic [23:0] stp;
    wave_t       wv;
    if ($urandom_range(99) < 60) begin
      tick();
    end else begin
      case ($urandom_range(3))
        0: g0 = 25'(FULL_GAIN);
        1: g0 = 25'($urandom_range(33554431, FULL_GAIN + 1));
        2: g0 = 25'($urandom_range(FULL_GAIN));
        default: g0 = 25'($urandom);
      endcase
      case ($urandom_range(2))
        0: gs = '0;
        1: begin
          gs = 24'($urandom_range(4000));
          if ($urandom_range(1)) begin
            gs = -gs;
          end
        end
        default: gs = 24'($urandom);
      endcase
      stp = $urandom_range(1) ? 24'($urandom_range(24'h0FFFFF)) : 24'($urandom);
      wv  = wave_t'($urandom_range(3));
      // many slots at full gain and matched phase push the sum past the rails
      if (loud) begin
        g0  = 25'(FULL_GAIN);
        gs  = '0;
        wv  = $urandom_range(3) == 0 ? WAVE_SINE : WAVE_TRI;
        stp = $urandom_range(1) ? 24'h800000 : 24'h000000;
      end
      load(4'($urandom), wv, stp, g0, gs);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed
    tick();
    load(4'd0, WAVE_SINE, 24'hFFFFFF, 25'(FULL_GAIN), 24'h000000);
    tick();
    tick();
    // over-range start gain clamps, steepest falling ramp hits zero
    load(4'd15, WAVE_TRI, 24'h400000, 25'h1FFFFFF, 24'h800000);
    tick();
    tick();
    tick();
    // silent noise ramping up to full scale
    load(4'd1, WAVE_NOISE, 24'h123456, 25'd0, 24'h7FFFFF);
    tick();
    tick();
    tick();
    load(4'd2, WAVE_TRI, 24'h800000, 25'(FULL_GAIN), 24'h000000);
    load(4'd3, WAVE_TRI, 24'h800000, 25'(FULL_GAIN), 24'h000000);
    load(4'd4, WAVE_TRI, 24'h800000, 25'(FULL_GAIN), 24'h000000);
    tick();
    tick();
    load(4'd0, WAVE_OFF, 24'hFFFFFF, 25'(FULL_GAIN), 24'h7FFFFF);
    load(4'd15, WAVE_OFF, 24'h000000, 25'd0, 24'h000000);
    tick();
    tick();
    drain();

    for (int i = 0; i < 400; i++) begin
      random_item(1'b0);
    end
    drain();

    // receiver holds off while ticks keep coming, so the block backs up
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      tick();
    end

    no_idle = 1'b1;
    for (int i = 0; i < 300; i++) begin
      random_item(i < 80);
    end
    no_idle = 1'b0;

    for (int i = 0; i < 440; i++) begin
      random_item($urandom_range(9) == 0);
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mom_pkg.sv
rtl/mom_ram.sv
rtl/mom_voice.sv
rtl/mom_mixer.sv
rtl/multi_oscillator_mixer.sv
sim/mix_checker.sv
sim/tb.sv
